// ===== hw/rtl/sqv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sqv_pkg;

    localparam int COORD_W = 32;
    localparam int DIM_W = 31;
    localparam int TEX_W = 16;
    localparam int COLOR_W = 32;
    localparam int ANGLE_W = 16;
    localparam int OP_W = 2;

    localparam int VERTS_PER_SPRITE = 6;
    localparam int VIDX_W = $clog2(VERTS_PER_SPRITE);
    localparam int NUM_CORNERS = 4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PLAIN   = 2'd0,
        OP_ROTATED = 2'd1,
        OP_FRAME   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_BL = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_TR = 2'd3
    } t_corner;

    // one prepared sprite: vertex position is base plus the corner offset
    typedef struct packed {
        logic [COORD_W-1:0]                  base_x;
        logic [COORD_W-1:0]                  base_y;
        logic [NUM_CORNERS-1:0][COORD_W-1:0] off_x;
        logic [NUM_CORNERS-1:0][COORD_W-1:0] off_y;
        logic [COORD_W-1:0]                  u0;
        logic [COORD_W-1:0]                  u1;
        logic [COORD_W-1:0]                  v0;
        logic [COORD_W-1:0]                  v1;
        logic [COLOR_W-1:0]                  color;
        logic [TEX_W-1:0]                    tex;
        logic                                new_batch;
    } t_sprite;

endpackage

`default_nettype wire

// ===== hw/rtl/sqv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sqv_sprite_if;
    import sqv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [DIM_W-1:0]          dest_w;
    logic [DIM_W-1:0]          dest_h;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
    logic signed [COORD_W-1:0] tex_w;
    logic signed [COORD_W-1:0] tex_h;
    logic [TEX_W-1:0]          texture_id;
    logic [COLOR_W-1:0]        color_rgba;
    logic [ANGLE_W-1:0]        angle;

    modport source (
        output valid, op, dest_x, dest_y, dest_w, dest_h, tex_u, tex_v, tex_w, tex_h,
        output texture_id, color_rgba, angle,
        input  ready
    );

    modport sink (
        input  valid, op, dest_x, dest_y, dest_w, dest_h, tex_u, tex_v, tex_w, tex_h,
        input  texture_id, color_rgba, angle,
        output ready
    );
endinterface

interface sqv_vertex_if;
    import sqv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] uv_u;
    logic signed [COORD_W-1:0] uv_v;
    logic [COLOR_W-1:0]        vertex_color;
    logic [TEX_W-1:0]          vertex_texture;
    logic [VIDX_W-1:0]         vertex_index;
    logic                      new_batch;
    logic                      last;

    modport source (
        output valid, pos_x, pos_y, uv_u, uv_v, vertex_color, vertex_texture,
        output vertex_index, new_batch, last,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, uv_u, uv_v, vertex_color, vertex_texture,
        input  vertex_index, new_batch, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sqv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqv_front #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    sqv_sprite_if.sink      i_spr,
    output logic            o_push_valid,
    input  wire logic       i_push_ready,
    output sqv_pkg::t_sprite o_push_data
);
    import sqv_pkg::*;

    localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
    localparam int QUARTER = TBL_SIZE / 4;
    localparam int ROM_AW = SINE_TABLE_BITS - 1;
    localparam int RW = SINE_TABLE_BITS - 2;
    localparam int MAG_W = 15;
    localparam int TRIG_W = MAG_W + 1;
    localparam int HALF_W = DIM_W - 1;
    localparam int PROD_W = HALF_W + 1 + TRIG_W;
    localparam int SUM_W = PROD_W + 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] MAG_MAX = 64'd32767;

    // quarter sine wave in unsigned Q0.15 from a fixed-point taylor series, elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        r;
        logic signed [63:0] s;
        x = (64'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        t = x;
        s = $signed(x);
        for (int n = 1; n <= 6; n++) begin
            t = (t * x2) >> 30;
            t = t / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
                s = s - $signed(t);
            end else begin
                s = s + $signed(t);
            end
        end
        if (s < 0) begin
            s = '0;
        end
        r = ($unsigned(s) + 64'd16384) >> 15;
        if (r > MAG_MAX) begin
            r = MAG_MAX;
        end
        return r[MAG_W-1:0];
    endfunction

    // fold a full-turn index onto the quarter wave
    function automatic logic [ROM_AW-1:0] fold_addr(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [ROM_AW-1:0] r;
        r = {1'b0, idx[RW-1:0]};
        if (idx[RW]) begin
            return ROM_AW'(QUARTER) - r;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] round_q15(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + SUM_W'(16384);
        return t[COORD_W+14:15];
    endfunction

    logic [MAG_W-1:0] w_rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        assign w_rom[g] = quarter_sine(g);
    end

    logic                       w_accept;
    logic                       w_is_sprite;
    logic                       w_s1_ready;
    logic                       w_s2_ready;
    logic [SINE_TABLE_BITS-1:0] w_idx_s;
    logic [SINE_TABLE_BITS-1:0] w_idx_c;
    logic [HALF_W-1:0]          w_hw;
    logic [HALF_W-1:0]          w_hh;

    logic                       r_s1_v;
    logic                       n_s1_v;
    logic                       r_s2_v;
    logic                       n_s2_v;
    logic                       r_have_prev;
    logic                       n_have_prev;
    logic [TEX_W-1:0]           r_prev_tex;
    logic [TEX_W-1:0]           n_prev_tex;

    logic                       r_s1_rot;
    logic [DIM_W-1:0]           r_s1_w;
    logic [DIM_W-1:0]           r_s1_h;
    logic [HALF_W-1:0]          r_s1_hw;
    logic [HALF_W-1:0]          r_s1_hh;
    logic [COORD_W-1:0]         r_s1_bx;
    logic [COORD_W-1:0]         r_s1_by;
    logic [COORD_W-1:0]         r_s1_u0;
    logic [COORD_W-1:0]         r_s1_u1;
    logic [COORD_W-1:0]         r_s1_v0;
    logic [COORD_W-1:0]         r_s1_v1;
    logic [COLOR_W-1:0]         r_s1_col;
    logic [TEX_W-1:0]           r_s1_tex;
    logic                       r_s1_nb;
    logic [MAG_W-1:0]           r_s1_sin_mag;
    logic                       r_s1_sin_neg;
    logic [MAG_W-1:0]           r_s1_cos_mag;
    logic                       r_s1_cos_neg;

    logic signed [TRIG_W-1:0]   w_sin;
    logic signed [TRIG_W-1:0]   w_cos;

    logic                       r_s2_rot;
    logic [DIM_W-1:0]           r_s2_w;
    logic [DIM_W-1:0]           r_s2_h;
    logic [COORD_W-1:0]         r_s2_bx;
    logic [COORD_W-1:0]         r_s2_by;
    logic [COORD_W-1:0]         r_s2_u0;
    logic [COORD_W-1:0]         r_s2_u1;
    logic [COORD_W-1:0]         r_s2_v0;
    logic [COORD_W-1:0]         r_s2_v1;
    logic [COLOR_W-1:0]         r_s2_col;
    logic [TEX_W-1:0]           r_s2_tex;
    logic                       r_s2_nb;
    logic signed [PROD_W-1:0]   r_s2_a;
    logic signed [PROD_W-1:0]   r_s2_b;
    logic signed [PROD_W-1:0]   r_s2_c;
    logic signed [PROD_W-1:0]   r_s2_d;

    logic signed [SUM_W-1:0]    w_ea;
    logic signed [SUM_W-1:0]    w_eb;
    logic signed [SUM_W-1:0]    w_ec;
    logic signed [SUM_W-1:0]    w_ed;
    logic [COORD_W-1:0]         w_w32;
    logic [COORD_W-1:0]         w_h32;

    assign w_s2_ready = !r_s2_v || i_push_ready;
    assign w_s1_ready = !r_s1_v || w_s2_ready;
    assign i_spr.ready = w_s1_ready;
    assign w_accept = i_spr.valid && w_s1_ready;
    assign w_is_sprite = i_spr.op inside {OP_PLAIN, OP_ROTATED};

    assign w_idx_s = i_spr.angle[ANGLE_W-1 -: SINE_TABLE_BITS];
    assign w_idx_c = w_idx_s + SINE_TABLE_BITS'(QUARTER);
    assign w_hw = i_spr.dest_w[DIM_W-1:1];
    assign w_hh = i_spr.dest_h[DIM_W-1:1];

    always_comb begin
        n_s1_v = w_s1_ready ? (w_accept && w_is_sprite) : r_s1_v;
        n_s2_v = w_s2_ready ? r_s1_v : r_s2_v;
        n_have_prev = r_have_prev;
        n_prev_tex = r_prev_tex;
        if (w_accept) begin
            case (i_spr.op)
                OP_PLAIN, OP_ROTATED: begin
                    n_have_prev = 1'b1;
                    n_prev_tex = i_spr.texture_id;
                end
                OP_FRAME: begin
                    n_have_prev = 1'b0;
                    n_prev_tex = '0;
                end
                default: begin
                    n_have_prev = r_have_prev;
                    n_prev_tex = r_prev_tex;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_tex <= '0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= n_s2_v;
            r_have_prev <= n_have_prev;
            r_prev_tex <= n_prev_tex;
        end
    end

    // stage 1: classify, origin and uv sums, sine table read
    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_rot <= (i_spr.op == OP_ROTATED);
            r_s1_w <= i_spr.dest_w;
            r_s1_h <= i_spr.dest_h;
            r_s1_hw <= w_hw;
            r_s1_hh <= w_hh;
            if (i_spr.op == OP_ROTATED) begin
                r_s1_bx <= i_spr.dest_x + COORD_W'(w_hw);
                r_s1_by <= i_spr.dest_y + COORD_W'(w_hh);
            end else begin
                r_s1_bx <= i_spr.dest_x - COORD_W'(w_hw);
                r_s1_by <= i_spr.dest_y - COORD_W'(w_hh);
            end
            r_s1_u0 <= i_spr.tex_u;
            r_s1_u1 <= i_spr.tex_u + i_spr.tex_w;
            r_s1_v0 <= i_spr.tex_v;
            r_s1_v1 <= i_spr.tex_v + i_spr.tex_h;
            r_s1_col <= i_spr.color_rgba;
            r_s1_tex <= i_spr.texture_id;
            r_s1_nb <= !r_have_prev || (i_spr.texture_id != r_prev_tex);
            r_s1_sin_mag <= w_rom[fold_addr(w_idx_s)];
            r_s1_sin_neg <= w_idx_s[SINE_TABLE_BITS-1];
            r_s1_cos_mag <= w_rom[fold_addr(w_idx_c)];
            r_s1_cos_neg <= w_idx_c[SINE_TABLE_BITS-1];
        end
    end

    assign w_sin = r_s1_sin_neg ? -$signed({1'b0, r_s1_sin_mag}) : $signed({1'b0, r_s1_sin_mag});
    assign w_cos = r_s1_cos_neg ? -$signed({1'b0, r_s1_cos_mag}) : $signed({1'b0, r_s1_cos_mag});

    // stage 2: half size times sine and cosine
    always_ff @(posedge i_clk) begin
        if (w_s2_ready) begin
            r_s2_rot <= r_s1_rot;
            r_s2_w <= r_s1_w;
            r_s2_h <= r_s1_h;
            r_s2_bx <= r_s1_bx;
            r_s2_by <= r_s1_by;
            r_s2_u0 <= r_s1_u0;
            r_s2_u1 <= r_s1_u1;
            r_s2_v0 <= r_s1_v0;
            r_s2_v1 <= r_s1_v1;
            r_s2_col <= r_s1_col;
            r_s2_tex <= r_s1_tex;
            r_s2_nb <= r_s1_nb;
            r_s2_a <= $signed({1'b0, r_s1_hw}) * w_cos;
            r_s2_b <= $signed({1'b0, r_s1_hh}) * w_sin;
            r_s2_c <= $signed({1'b0, r_s1_hw}) * w_sin;
            r_s2_d <= $signed({1'b0, r_s1_hh}) * w_cos;
        end
    end

    assign w_ea = SUM_W'(r_s2_a);
    assign w_eb = SUM_W'(r_s2_b);
    assign w_ec = SUM_W'(r_s2_c);
    assign w_ed = SUM_W'(r_s2_d);
    assign w_w32 = COORD_W'(r_s2_w);
    assign w_h32 = COORD_W'(r_s2_h);

    // corner offsets, rounded rotation or plain rectangle
    always_comb begin
        o_push_data = '0;
        o_push_data.base_x = r_s2_bx;
        o_push_data.base_y = r_s2_by;
        o_push_data.u0 = r_s2_u0;
        o_push_data.u1 = r_s2_u1;
        o_push_data.v0 = r_s2_v0;
        o_push_data.v1 = r_s2_v1;
        o_push_data.color = r_s2_col;
        o_push_data.tex = r_s2_tex;
        o_push_data.new_batch = r_s2_nb;
        if (r_s2_rot) begin
            o_push_data.off_x[CORNER_TL] = round_q15(-w_ea - w_eb);
            o_push_data.off_x[CORNER_BL] = round_q15(-w_ea + w_eb);
            o_push_data.off_x[CORNER_BR] = round_q15(w_ea + w_eb);
            o_push_data.off_x[CORNER_TR] = round_q15(w_ea - w_eb);
            o_push_data.off_y[CORNER_TL] = round_q15(-w_ec + w_ed);
            o_push_data.off_y[CORNER_BL] = round_q15(-w_ec - w_ed);
            o_push_data.off_y[CORNER_BR] = round_q15(w_ec - w_ed);
            o_push_data.off_y[CORNER_TR] = round_q15(w_ec + w_ed);
        end else begin
            o_push_data.off_x[CORNER_TL] = '0;
            o_push_data.off_x[CORNER_BL] = '0;
            o_push_data.off_x[CORNER_BR] = w_w32;
            o_push_data.off_x[CORNER_TR] = w_w32;
            o_push_data.off_y[CORNER_TL] = w_h32;
            o_push_data.off_y[CORNER_BL] = '0;
            o_push_data.off_y[CORNER_BR] = '0;
            o_push_data.off_y[CORNER_TR] = w_h32;
        end
    end

    assign o_push_valid = r_s2_v;

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_spr.op == OP_FRAME) |=> !r_have_prev)
        else $error("frame start did not clear batch state");

    a_sprite_records_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_sprite) |=> (r_have_prev && r_prev_tex == $past(i_spr.texture_id)))
        else $error("sprite texture not recorded");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !i_push_ready) |=> r_s2_v)
        else $error("stalled sprite dropped before queue");

endmodule

`default_nettype wire

// ===== hw/rtl/sqv_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqv_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire sqv_pkg::t_sprite  i_push_data,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output sqv_pkg::t_sprite       o_pop_data
);
    import sqv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_sprite          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data = r_mem[r_rptr];
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("push without pop did not grow queue");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("pop without push did not shrink queue");

endmodule

`default_nettype wire

// ===== hw/rtl/sqv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqv_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pop_valid,
    output logic                   o_pop_ready,
    input  wire sqv_pkg::t_sprite  i_pop_data,
    sqv_vertex_if.source           o_vtx
);
    import sqv_pkg::*;

    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VERTS_PER_SPRITE - 1);

    // triangle order TL BL BR, BR TR TL
    function automatic t_corner corner_of(input logic [VIDX_W-1:0] k);
        case (k)
            3'd0:    return CORNER_TL;
            3'd1:    return CORNER_BL;
            3'd2:    return CORNER_BR;
            3'd3:    return CORNER_BR;
            3'd4:    return CORNER_TR;
            default: return CORNER_TL;
        endcase
    endfunction

    logic [VIDX_W-1:0]  r_vidx;
    logic [VIDX_W-1:0]  n_vidx;
    logic               r_ov;
    logic               n_ov;
    t_corner            w_c;
    logic               w_last;
    logic               w_load;

    logic [COORD_W-1:0] r_pos_x;
    logic [COORD_W-1:0] r_pos_y;
    logic [COORD_W-1:0] r_uv_u;
    logic [COORD_W-1:0] r_uv_v;
    logic [COLOR_W-1:0] r_color;
    logic [TEX_W-1:0]   r_tex;
    logic [VIDX_W-1:0]  r_idx;
    logic               r_nb;
    logic               r_last;

    assign w_c = corner_of(r_vidx);
    assign w_last = (r_vidx == LAST_IDX);
    assign w_load = i_pop_valid && (!r_ov || o_vtx.ready);
    assign o_pop_ready = w_load && w_last;

    always_comb begin
        n_ov = r_ov;
        n_vidx = r_vidx;
        if (w_load) begin
            n_ov = 1'b1;
            n_vidx = w_last ? '0 : r_vidx + 1'b1;
        end else if (o_vtx.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_vidx <= '0;
        end else begin
            r_ov <= n_ov;
            r_vidx <= n_vidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pos_x <= i_pop_data.base_x + i_pop_data.off_x[w_c];
            r_pos_y <= i_pop_data.base_y + i_pop_data.off_y[w_c];
            r_uv_u <= (w_c inside {CORNER_BR, CORNER_TR}) ? i_pop_data.u1 : i_pop_data.u0;
            r_uv_v <= (w_c inside {CORNER_TL, CORNER_TR}) ? i_pop_data.v1 : i_pop_data.v0;
            r_color <= i_pop_data.color;
            r_tex <= i_pop_data.tex;
            r_idx <= r_vidx;
            r_nb <= i_pop_data.new_batch && (r_vidx == '0);
            r_last <= w_last;
        end
    end

    assign o_vtx.valid = r_ov;
    assign o_vtx.pos_x = r_pos_x;
    assign o_vtx.pos_y = r_pos_y;
    assign o_vtx.uv_u = r_uv_u;
    assign o_vtx.uv_v = r_uv_v;
    assign o_vtx.vertex_color = r_color;
    assign o_vtx.vertex_texture = r_tex;
    assign o_vtx.vertex_index = r_idx;
    assign o_vtx.new_batch = r_nb;
    assign o_vtx.last = r_last;

    a_batch_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.new_batch) |-> o_vtx.vertex_index == '0)
        else $error("new batch flag off the first vertex");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.last) |-> o_vtx.vertex_index == LAST_IDX)
        else $error("last flag off the final vertex");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vidx != '0) |-> i_pop_valid)
        else $error("sprite left queue before all vertices sent");

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_quad_vertex_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  modport  payload
// i_sprite   in   sink     op, dest rect, tex rect, texture_id, color_rgba, angle
// o_vertex   out  source   pos, uv, color, texture, vertex_index, new_batch, last
//
// a sprite request gives six vertices at the vertex output register, one per cycle while
// the output is ready; frame start and unused ops give no vertices
// the first vertex passes two front stages, the queue and the output register
// synchronous active-low reset clears batch state, queue and valids; the sine rom is constant
// a stalled output holds the back end; the two-entry queue lets the front keep accepting

module sprite_quad_vertex_gen #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sqv_sprite_if.sink     i_sprite,
    sqv_vertex_if.source   o_vertex
);
    import sqv_pkg::*;

    logic    w_push_valid;
    logic    w_push_ready;
    t_sprite w_push_data;
    logic    w_pop_valid;
    logic    w_pop_ready;
    t_sprite w_pop_data;

    sqv_front #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_spr        (i_sprite),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    sqv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    sqv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_vtx       (o_vertex)
    );

endmodule

`default_nettype wire
